@@ rtl/lcpo_pkg.sv @@
// Shared types and constants of the line crossing point optimizer.
package lcpo_pkg;

	localparam int OUTCOME_BITS = 3;
	localparam int ADDR_BITS    = 4;
	localparam int DATA_BITS    = 32;

	// Register word indexes on the configuration port.
	localparam logic [1:0] REG_BEGIN_X = 2'd0;
	localparam logic [1:0] REG_BEGIN_Y = 2'd1;
	localparam logic [1:0] REG_END_X   = 2'd2;
	localparam logic [1:0] REG_END_Y   = 2'd3;

	typedef enum logic [OUTCOME_BITS-1:0] {
		OC_INTERIOR    = 3'd0,
		OC_AT_BEGIN    = 3'd1,
		OC_AT_END      = 3'd2,
		OC_HELD_DEGEN  = 3'd3,
		OC_HELD_COLLIN = 3'd4
	} outcome_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK,
		S_L2A, S_L2B, S_CDA, S_CDB, S_GOAL,
		S_DDA, S_DDB, S_CCA, S_CCB, S_DCA, S_DCB, S_ADJ,
		S_NMA, S_NMB, S_NRM, S_LDN, S_CMP,
		S_QXM, S_QXD, S_QYM, S_QYD, S_FIN
	} state_t;

endpackage

@@ rtl/lcpo_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface lcpo_in_if #(parameter int W = 24) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] prev_x;
	logic signed [W-1:0] prev_y;
	logic signed [W-1:0] next_x;
	logic signed [W-1:0] next_y;

	modport source (output valid, prev_x, prev_y, next_x, next_y, input ready);
	modport sink   (input valid, prev_x, prev_y, next_x, next_y, output ready);
endinterface

interface lcpo_out_if #(parameter int W = 24) ();
	logic                                  valid;
	logic                                  ready;
	logic signed [W-1:0]                   opt_x;
	logic signed [W-1:0]                   opt_y;
	logic [lcpo_pkg::OUTCOME_BITS-1:0]     outcome;

	modport source (output valid, opt_x, opt_y, outcome, input ready);
	modport sink   (input valid, opt_x, opt_y, outcome, output ready);
endinterface

@@ rtl/line_crossing_point_optimizer.sv @@
// Line crossing point optimizer: bit-serial multiply and divide over a configured segment.
//
// Usage:
//   Program the segment A-B through the APB port (begin_x, begin_y, end_x, end_y at
//   byte addresses 0, 4, 8, 12) while the block is idle. Each input item on item_in
//   carries the previous and the next route point; a next point of (0,0) means goal.
//   Each item yields exactly one result item on result_out: the chosen point on A-B
//   (which also becomes the held point) and an outcome code.
// Timing:
//   One item is worked at a time. A shift-add multiplier retires one multiplier bit
//   per cycle and a restoring divider one quotient bit per cycle, both shared by all
//   products and both coordinates. Endpoint and degenerate cases go straight from the
//   check to the result; a full crossing runs the chain of multiplies and the two
//   divisions of 5*COORD_BITS+8 bits.
// Reset and stall:
//   Reset clears the segment, the held point and all control state. The result sits
//   in an output register; a new item is taken while it waits, and the finished next
//   result holds in the sequencer until the receiver takes the waiting one.
module line_crossing_point_optimizer #(
	parameter int COORD_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lcpo_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [lcpo_pkg::DATA_BITS-1:0]    pwdata,
	output logic [lcpo_pkg::DATA_BITS-1:0]    prdata,
	output logic                              pready,
	lcpo_in_if.sink                           item_in,
	lcpo_out_if.source                        result_out
);

	localparam int C  = COORD_BITS;
	localparam int WW = 5*COORD_BITS + 8;   // widest intermediate: coordinate times numerator
	localparam int CW = $clog2(WW + 1);
	localparam logic [CW-1:0] N_COORD = CW'(C + 1);
	localparam logic [CW-1:0] N_CROSS = CW'(2*C + 3);
	localparam logic [CW-1:0] N_DEN   = CW'(2*C + 4);
	localparam logic [CW-1:0] N_DIV   = CW'(WW);

	// Configuration registers
	logic signed [C-1:0] begin_x_q, begin_y_q, end_x_q, end_y_q;

	// Captured item and derived differences
	logic signed [C-1:0] prev_x_q, prev_y_q, next_x_q, next_y_q;
	logic signed [C:0]   bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
	logic                goal_q;

	// Wide intermediates
	logic signed [WW-1:0] l2_q, cdot_q, ddot_q, ccr_q, dcr_q, den_q, num_q;
	logic [WW-1:0]        dvs_q;

	// Shift-add multiplier
	logic signed [WW-1:0] acc_q, ma_q, mb_q, acc_nx;
	logic [CW-1:0]        cnt_q;

	// Restoring divider
	logic [WW-1:0] rem_q, dq_q, quo_q, rem_sh, quo_nx, rem_nx;
	logic signed [WW-1:0] q_signed;
	logic          qneg_q;

	// Held point and result register
	logic signed [C-1:0] held_x_q, held_y_q, opt_x_q, opt_y_q;
	lcpo_pkg::outcome_t  oc_q, out_oc_q;
	logic                out_valid_q;

	lcpo_pkg::state_t state_q, state_nx;

	// Control from the sequencer
	logic                 mul_en, mul_clr, mul_sub, div_en;
	logic signed [WW-1:0] mul_a, mul_b;
	logic [CW-1:0]        mul_n;
	logic                 mul_last, div_last;

	logic cfg_wr;
	logic deg, at_a, at_b, goal_in;
	logic signed [WW-1:0] dcr_adj, den_adj, num_fix, den_fix;
	logic                 out_free;

	function automatic logic signed [WW-1:0] ext(input logic signed [C:0] v);
		ext = WW'(v);
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_x_q <= '0;
			begin_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lcpo_pkg::REG_BEGIN_X: begin_x_q <= pwdata[C-1:0];
				lcpo_pkg::REG_BEGIN_Y: begin_y_q <= pwdata[C-1:0];
				lcpo_pkg::REG_END_X:   end_x_q   <= pwdata[C-1:0];
				lcpo_pkg::REG_END_Y:   end_y_q   <= pwdata[C-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lcpo_pkg::REG_BEGIN_X: prdata = lcpo_pkg::DATA_BITS'(begin_x_q);
			lcpo_pkg::REG_BEGIN_Y: prdata = lcpo_pkg::DATA_BITS'(begin_y_q);
			lcpo_pkg::REG_END_X:   prdata = lcpo_pkg::DATA_BITS'(end_x_q);
			lcpo_pkg::REG_END_Y:   prdata = lcpo_pkg::DATA_BITS'(end_y_q);
			default:               prdata = '0;
		endcase
	end

	// ---------------- item handshake ----------------
	assign item_in.ready      = (state_q == lcpo_pkg::S_IDLE);
	assign out_free           = !out_valid_q || result_out.ready;
	assign result_out.valid   = out_valid_q;
	assign result_out.opt_x   = opt_x_q;
	assign result_out.opt_y   = opt_y_q;
	assign result_out.outcome = out_oc_q;

	// Early checks on the captured item
	assign deg = (begin_x_q == end_x_q && begin_y_q == end_y_q) ||
	             (prev_x_q == next_x_q && prev_y_q == next_y_q);
	assign at_a = (begin_x_q == prev_x_q && begin_y_q == prev_y_q) ||
	              (begin_x_q == next_x_q && begin_y_q == next_y_q);
	assign at_b = (end_x_q == prev_x_q && end_y_q == prev_y_q) ||
	              (end_x_q == next_x_q && end_y_q == next_y_q);
	assign goal_in = (item_in.next_x[C-1:0] == '0) && (item_in.next_y[C-1:0] == '0);

	// Flip the next point to the far side when both lie on the same side
	assign dcr_adj = (ccr_q[WW-1] == dcr_q[WW-1]) ? -dcr_q : dcr_q;
	assign den_adj = dcr_adj - ccr_q;
	assign num_fix = den_q[WW-1] ? -num_q : num_q;
	assign den_fix = den_q[WW-1] ? -den_q : den_q;

	// ---------------- multiplier datapath ----------------
	assign mul_last = mul_en && (cnt_q == mul_n);
	assign div_last = div_en && (cnt_q == N_DIV);

	always_comb begin
		acc_nx = acc_q;
		if (mb_q[0]) begin
			// the top multiplier bit carries negative weight
			if (mul_sub ^ (cnt_q == mul_n))
				acc_nx = acc_q - ma_q;
			else
				acc_nx = acc_q + ma_q;
		end
	end

	// ---------------- divider datapath ----------------
	always_comb begin
		rem_sh = {rem_q[WW-2:0], dq_q[WW-1]};
		if (rem_sh >= dvs_q) begin
			rem_nx = rem_sh - dvs_q;
			quo_nx = {quo_q[WW-2:0], 1'b1};
		end else begin
			rem_nx = rem_sh;
			quo_nx = {quo_q[WW-2:0], 1'b0};
		end
		q_signed = qneg_q ? -$signed(quo_nx) : $signed(quo_nx);
	end

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lcpo_pkg::S_IDLE: if (item_in.valid) state_nx = lcpo_pkg::S_CHK;
			lcpo_pkg::S_CHK: begin
				if (deg || at_a || at_b) state_nx = lcpo_pkg::S_FIN;
				else                     state_nx = lcpo_pkg::S_L2A;
			end
			lcpo_pkg::S_L2A: if (mul_last) state_nx = lcpo_pkg::S_L2B;
			lcpo_pkg::S_L2B: if (mul_last) state_nx = lcpo_pkg::S_CDA;
			lcpo_pkg::S_CDA: if (mul_last) state_nx = lcpo_pkg::S_CDB;
			lcpo_pkg::S_CDB: begin
				if (mul_last) state_nx = goal_q ? lcpo_pkg::S_GOAL : lcpo_pkg::S_DDA;
			end
			lcpo_pkg::S_GOAL: begin
				if (cdot_q[WW-1] || cdot_q == '0 || cdot_q >= l2_q)
					state_nx = lcpo_pkg::S_FIN;
				else
					state_nx = lcpo_pkg::S_QXM;
			end
			lcpo_pkg::S_DDA: if (mul_last) state_nx = lcpo_pkg::S_DDB;
			lcpo_pkg::S_DDB: if (mul_last) state_nx = lcpo_pkg::S_CCA;
			lcpo_pkg::S_CCA: if (mul_last) state_nx = lcpo_pkg::S_CCB;
			lcpo_pkg::S_CCB: if (mul_last) state_nx = lcpo_pkg::S_DCA;
			lcpo_pkg::S_DCA: if (mul_last) state_nx = lcpo_pkg::S_DCB;
			lcpo_pkg::S_DCB: if (mul_last) state_nx = lcpo_pkg::S_ADJ;
			lcpo_pkg::S_ADJ: begin
				if (den_adj == '0) state_nx = lcpo_pkg::S_FIN;
				else               state_nx = lcpo_pkg::S_NMA;
			end
			lcpo_pkg::S_NMA: if (mul_last) state_nx = lcpo_pkg::S_NMB;
			lcpo_pkg::S_NMB: if (mul_last) state_nx = lcpo_pkg::S_NRM;
			lcpo_pkg::S_NRM: begin
				if (num_fix[WW-1]) state_nx = lcpo_pkg::S_FIN;
				else               state_nx = lcpo_pkg::S_LDN;
			end
			lcpo_pkg::S_LDN: if (mul_last) state_nx = lcpo_pkg::S_CMP;
			lcpo_pkg::S_CMP: begin
				if (num_q > acc_q) state_nx = lcpo_pkg::S_FIN;
				else               state_nx = lcpo_pkg::S_QXM;
			end
			lcpo_pkg::S_QXM: if (mul_last) state_nx = lcpo_pkg::S_QXD;
			lcpo_pkg::S_QXD: if (div_last) state_nx = lcpo_pkg::S_QYM;
			lcpo_pkg::S_QYM: if (mul_last) state_nx = lcpo_pkg::S_QYD;
			lcpo_pkg::S_QYD: if (div_last) state_nx = lcpo_pkg::S_FIN;
			lcpo_pkg::S_FIN: if (out_free) state_nx = lcpo_pkg::S_IDLE;
			default: state_nx = lcpo_pkg::S_IDLE;
		endcase
	end

	// ---------------- sequencer: unit controls ----------------
	always_comb begin
		mul_en  = 1'b1;
		mul_clr = 1'b1;
		mul_sub = 1'b0;
		div_en  = 1'b0;
		mul_a   = ext(bx_q);
		mul_b   = ext(bx_q);
		mul_n   = N_COORD;
		unique case (state_q)
			lcpo_pkg::S_L2A: ;
			lcpo_pkg::S_L2B: begin
				mul_clr = 1'b0; mul_a = ext(by_q); mul_b = ext(by_q);
			end
			lcpo_pkg::S_CDA: mul_b = ext(cx_q);
			lcpo_pkg::S_CDB: begin
				mul_clr = 1'b0; mul_a = ext(by_q); mul_b = ext(cy_q);
			end
			lcpo_pkg::S_DDA: mul_b = ext(dx_q);
			lcpo_pkg::S_DDB: begin
				mul_clr = 1'b0; mul_a = ext(by_q); mul_b = ext(dy_q);
			end
			lcpo_pkg::S_CCA: mul_b = ext(cy_q);
			lcpo_pkg::S_CCB: begin
				mul_clr = 1'b0; mul_sub = 1'b1; mul_a = ext(by_q); mul_b = ext(cx_q);
			end
			lcpo_pkg::S_DCA: mul_b = ext(dy_q);
			lcpo_pkg::S_DCB: begin
				mul_clr = 1'b0; mul_sub = 1'b1; mul_a = ext(by_q); mul_b = ext(dx_q);
			end
			lcpo_pkg::S_NMA: begin
				mul_a = cdot_q; mul_b = dcr_q; mul_n = N_CROSS;
			end
			lcpo_pkg::S_NMB: begin
				mul_clr = 1'b0; mul_sub = 1'b1;
				mul_a = ddot_q; mul_b = ccr_q; mul_n = N_CROSS;
			end
			lcpo_pkg::S_LDN: begin
				mul_a = l2_q; mul_b = den_q; mul_n = N_DEN;
			end
			lcpo_pkg::S_QXM: mul_a = num_q;
			lcpo_pkg::S_QYM: begin
				mul_a = num_q; mul_b = ext(by_q);
			end
			lcpo_pkg::S_QXD, lcpo_pkg::S_QYD: begin
				mul_en = 1'b0; div_en = 1'b1;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcpo_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
		end else begin
			state_q <= state_nx;
			// step counter restarts at every unit hand-over
			if (mul_last || div_last || (!mul_en && !div_en)) cnt_q <= '0;
			else                                              cnt_q <= cnt_q + 1'b1;

			if (state_q == lcpo_pkg::S_FIN && out_free) out_valid_q <= 1'b1;
			else if (result_out.ready)                   out_valid_q <= 1'b0;

			// update the held point at each decision
			unique case (state_q)
				lcpo_pkg::S_CHK: begin
					if (!deg && at_a) begin
						held_x_q <= begin_x_q; held_y_q <= begin_y_q;
					end else if (!deg && at_b) begin
						held_x_q <= end_x_q;   held_y_q <= end_y_q;
					end
				end
				lcpo_pkg::S_GOAL: begin
					if (cdot_q[WW-1] || cdot_q == '0) begin
						held_x_q <= begin_x_q; held_y_q <= begin_y_q;
					end else if (cdot_q >= l2_q) begin
						held_x_q <= end_x_q;   held_y_q <= end_y_q;
					end
				end
				lcpo_pkg::S_NRM: begin
					if (num_fix[WW-1]) begin
						held_x_q <= begin_x_q; held_y_q <= begin_y_q;
					end
				end
				lcpo_pkg::S_CMP: begin
					if (num_q > acc_q) begin
						held_x_q <= end_x_q;   held_y_q <= end_y_q;
					end
				end
				lcpo_pkg::S_QXD: if (div_last) held_x_q <= begin_x_q + q_signed[C-1:0];
				lcpo_pkg::S_QYD: if (div_last) held_y_q <= begin_y_q + q_signed[C-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			prev_x_q <= item_in.prev_x;
			prev_y_q <= item_in.prev_y;
			next_x_q <= item_in.next_x;
			next_y_q <= item_in.next_y;
			goal_q   <= goal_in;
		end

		if (state_q == lcpo_pkg::S_CHK) begin
			bx_q <= (C+1)'(end_x_q)  - (C+1)'(begin_x_q);
			by_q <= (C+1)'(end_y_q)  - (C+1)'(begin_y_q);
			cx_q <= (C+1)'(prev_x_q) - (C+1)'(begin_x_q);
			cy_q <= (C+1)'(prev_y_q) - (C+1)'(begin_y_q);
			dx_q <= (C+1)'(next_x_q) - (C+1)'(begin_x_q);
			dy_q <= (C+1)'(next_y_q) - (C+1)'(begin_y_q);
			if (deg)       oc_q <= lcpo_pkg::OC_HELD_DEGEN;
			else if (at_a) oc_q <= lcpo_pkg::OC_AT_BEGIN;
			else if (at_b) oc_q <= lcpo_pkg::OC_AT_END;
			else           oc_q <= lcpo_pkg::OC_INTERIOR;
		end

		// multiplier: load on step zero, then one multiplier bit per cycle
		if (mul_en) begin
			if (cnt_q == '0) begin
				ma_q <= mul_a;
				mb_q <= mul_b;
				if (mul_clr) acc_q <= '0;
			end else begin
				acc_q <= acc_nx;
				ma_q  <= ma_q <<< 1;
				mb_q  <= mb_q >>> 1;
			end
		end

		if (mul_last) begin
			unique case (state_q)
				lcpo_pkg::S_L2B: l2_q   <= acc_nx;
				lcpo_pkg::S_CDB: cdot_q <= acc_nx;
				lcpo_pkg::S_DDB: ddot_q <= acc_nx;
				lcpo_pkg::S_CCB: ccr_q  <= acc_nx;
				lcpo_pkg::S_DCB: dcr_q  <= acc_nx;
				lcpo_pkg::S_NMB: num_q  <= acc_nx;
				lcpo_pkg::S_LDN: dvs_q  <= acc_nx;
				default: ;
			endcase
		end

		unique case (state_q)
			lcpo_pkg::S_GOAL: begin
				num_q <= cdot_q;
				dvs_q <= l2_q;
				if (cdot_q[WW-1] || cdot_q == '0) oc_q <= lcpo_pkg::OC_AT_BEGIN;
				else if (cdot_q >= l2_q)          oc_q <= lcpo_pkg::OC_AT_END;
			end
			lcpo_pkg::S_ADJ: begin
				dcr_q <= dcr_adj;
				den_q <= den_adj;
				if (den_adj == '0) oc_q <= lcpo_pkg::OC_HELD_COLLIN;
			end
			lcpo_pkg::S_NRM: begin
				num_q <= num_fix;
				den_q <= den_fix;
				if (num_fix[WW-1]) oc_q <= lcpo_pkg::OC_AT_BEGIN;
			end
			lcpo_pkg::S_CMP: if (num_q > acc_q) oc_q <= lcpo_pkg::OC_AT_END;
			default: ;
		endcase

		// divider: take the magnitude of the product, then one quotient bit per cycle
		if (div_en) begin
			if (cnt_q == '0) begin
				dq_q   <= acc_q[WW-1] ? WW'(-acc_q) : WW'(acc_q);
				qneg_q <= acc_q[WW-1];
				rem_q  <= '0;
				quo_q  <= '0;
			end else begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				dq_q  <= dq_q << 1;
			end
		end

		if (state_q == lcpo_pkg::S_FIN && out_free) begin
			opt_x_q  <= held_x_q;
			opt_y_q  <= held_y_q;
			out_oc_q <= oc_q;
		end
	end

	// ---------------- assertions ----------------
	// never divide by zero
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(div_en && cnt_q != '0) |-> (dvs_q != '0))
		else $error("divider runs with zero divisor");

	// a new result carries the held point
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (opt_x_q == held_x_q && opt_y_q == held_y_q))
		else $error("result differs from held point");

	// the step counter never runs past the active unit's length
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_en |-> cnt_q <= mul_n) and (div_en |-> cnt_q <= N_DIV))
		else $error("step counter overran");

	// a result is only loaded while the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_out.ready) |=> $stable(opt_x_q) && $stable(out_oc_q))
		else $error("waiting result overwritten");

endmodule

@@ verif/lcpo_checker.sv @@
// Scoreboard for the line crossing point optimizer: predicts each result and compares it.
`timescale 1ns / 1ps
module lcpo_checker #(
	parameter int W = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [lcpo_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lcpo_pkg::DATA_BITS-1:0] pwdata,
	lcpo_in_if                             in_ch,
	lcpo_out_if                            out_ch,
	output int                             fail_count,
	output int                             pending
);

	typedef logic signed [255:0] wide_t;
	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		lcpo_pkg::outcome_t  oc;
	} crossing_t;

	logic signed [W-1:0] seg_ax, seg_ay, seg_ex, seg_ey;
	logic signed [W-1:0] held_x, held_y;
	crossing_t           expected_q[$];

	assign pending = expected_q.size();

	function automatic crossing_t find_crossing(input logic signed [W-1:0] px_i, py_i,
			nx_i, ny_i);
		wide_t ax, ay, ex, ey, px, py, nx, ny, bx, by, l2;
		wide_t cx, cy, dx, dy, cdot, ddot, ccr, dcr, den, num, div;
		crossing_t r;
		ax = wide_t'(seg_ax); ay = wide_t'(seg_ay);
		ex = wide_t'(seg_ex); ey = wide_t'(seg_ey);
		px = wide_t'(px_i); py = wide_t'(py_i);
		nx = wide_t'(nx_i); ny = wide_t'(ny_i);
		bx = ex - ax; by = ey - ay;
		l2 = bx * bx + by * by;
		num = 0; div = 1;
		r.oc = lcpo_pkg::OC_INTERIOR;
		if ((ax == ex && ay == ey) || (px == nx && py == ny)) begin
			r.oc = lcpo_pkg::OC_HELD_DEGEN;
		end else if ((ax == px && ay == py) || (ax == nx && ay == ny)) begin
			r.oc = lcpo_pkg::OC_AT_BEGIN;
		end else if ((ex == px && ey == py) || (ex == nx && ey == ny)) begin
			r.oc = lcpo_pkg::OC_AT_END;
		end else begin
			cx = px - ax; cy = py - ay;
			cdot = bx * cx + by * cy;
			if (nx == 0 && ny == 0) begin
				// goal: project prev onto the segment
				if (cdot <= 0) r.oc = lcpo_pkg::OC_AT_BEGIN;
				else if (cdot >= l2) r.oc = lcpo_pkg::OC_AT_END;
				else begin
					num = cdot; div = l2;
				end
			end else begin
				dx = nx - ax; dy = ny - ay;
				ddot = bx * dx + by * dy;
				ccr = bx * cy - by * cx;
				dcr = bx * dy - by * dx;
				// mirror next across the line when both lie on one side
				if ((ccr < 0) == (dcr < 0)) dcr = -dcr;
				den = dcr - ccr;
				if (den == 0) begin
					r.oc = lcpo_pkg::OC_HELD_COLLIN;
				end else begin
					num = cdot * dcr - ddot * ccr;
					if (den < 0) begin
						den = -den; num = -num;
					end
					if (num < 0) r.oc = lcpo_pkg::OC_AT_BEGIN;
					else if (num > l2 * den) r.oc = lcpo_pkg::OC_AT_END;
					else div = den * l2;
				end
			end
		end
		case (r.oc)
			lcpo_pkg::OC_AT_BEGIN: begin
				held_x = seg_ax; held_y = seg_ay;
			end
			lcpo_pkg::OC_AT_END: begin
				held_x = seg_ex; held_y = seg_ey;
			end
			lcpo_pkg::OC_INTERIOR: begin
				held_x = W'(ax + (bx * num) / div);
				held_y = W'(ay + (by * num) / div);
			end
			default: ;
		endcase
		r.x = held_x;
		r.y = held_y;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crossing_t want;
		if (!arst_n) begin
			seg_ax = '0; seg_ay = '0; seg_ex = '0; seg_ey = '0;
			held_x = '0; held_y = '0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					lcpo_pkg::REG_BEGIN_X: seg_ax = pwdata[W-1:0];
					lcpo_pkg::REG_BEGIN_Y: seg_ay = pwdata[W-1:0];
					lcpo_pkg::REG_END_X:   seg_ex = pwdata[W-1:0];
					lcpo_pkg::REG_END_Y:   seg_ey = pwdata[W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result item with nothing expected");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (out_ch.opt_x !== want.x) begin
						$error("opt_x expected %0d got %0d", want.x, out_ch.opt_x);
						fail_count++;
					end
					if (out_ch.opt_y !== want.y) begin
						$error("opt_y expected %0d got %0d", want.y, out_ch.opt_y);
						fail_count++;
					end
					if (out_ch.outcome !== want.oc) begin
						$error("outcome expected %0d got %0d", want.oc, out_ch.outcome);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(find_crossing(in_ch.prev_x, in_ch.prev_y,
					in_ch.next_x, in_ch.next_y));
		end
	end

endmodule

@@ verif/tb.sv @@
// Testbench top: stimulus, configuration and verdict for the line crossing point optimizer.
`timescale 1ns / 1ps
module tb;

	localparam int W         = 24;
	localparam int CMAX      = (1 << (W - 1)) - 1;
	localparam int CMIN      = -(1 << (W - 1));
	localparam int IDLE_MAX  = 20000;
	localparam int PHASE_LEN = 200;

	logic                           clk;
	logic                           arst_n;
	logic                           psel, penable, pwrite;
	logic [lcpo_pkg::ADDR_BITS-1:0] paddr;
	logic [lcpo_pkg::DATA_BITS-1:0] pwdata;
	logic [lcpo_pkg::DATA_BITS-1:0] prdata;
	logic                           pready;
	int                             fail_count, pending;
	int                             send_idle_pct, recv_stall_pct;
	int                             idle_cycles;
	// local copy of the segment, used to aim stimulus
	int                             cfg_ax, cfg_ay, cfg_ex, cfg_ey;

	lcpo_in_if  #(.W(W)) in_ch ();
	lcpo_out_if #(.W(W)) out_ch ();

	line_crossing_point_optimizer #(.COORD_BITS(W)) u_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.item_in(in_ch), .result_out(out_ch)
	);

	lcpo_checker #(.W(W)) u_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_ch(in_ch), .out_ch(out_ch), .fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stall the result side at the phase's rate
	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int clip(input longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return int'(v);
	endfunction

	task automatic reg_write(input logic [1:0] idx, input int value);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = lcpo_pkg::ADDR_BITS'(idx) << 2;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// drain, let the block settle, then load a new segment
	task automatic set_segment(input int ax, ay, ex, ey);
		while (pending != 0) @(negedge clk);
		in_ch.valid = 1'b0;
		repeat (20) @(negedge clk);
		reg_write(lcpo_pkg::REG_BEGIN_X, ax);
		reg_write(lcpo_pkg::REG_BEGIN_Y, ay);
		reg_write(lcpo_pkg::REG_END_X, ex);
		reg_write(lcpo_pkg::REG_END_Y, ey);
		cfg_ax = ax; cfg_ay = ay; cfg_ex = ex; cfg_ey = ey;
	endtask

	task automatic send(input int px, py, nx, ny);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid  = 1'b1;
		in_ch.prev_x = W'(px); in_ch.prev_y = W'(py);
		in_ch.next_x = W'(nx); in_ch.next_y = W'(ny);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		// drop valid so the item is not taken twice
		in_ch.valid = 1'b0;
	endtask

	// pick one random item, biased toward the segment and its special cases
	task automatic send_random();
		int  px, py, nx, ny, span, sel, k, m;
		longint bx, by;
		bx = longint'(cfg_ex) - cfg_ax;
		by = longint'(cfg_ey) - cfg_ay;
		span = clip((bx < 0 ? -bx : bx) + (by < 0 ? -by : by) + 16);
		if (span < 0) span = CMAX;
		px = clip(longint'(cfg_ax) + $urandom_range(0, 2 * span) - span);
		py = clip(longint'(cfg_ay) + $urandom_range(0, 2 * span) - span);
		nx = clip(longint'(cfg_ax) + $urandom_range(0, 2 * span) - span);
		ny = clip(longint'(cfg_ay) + $urandom_range(0, 2 * span) - span);
		sel = $urandom_range(99);
		if (sel < 25) begin
			px = int'($urandom); py = int'($urandom);
			nx = int'($urandom); ny = int'($urandom);
		end else if (sel < 60) begin
			// keep the points near the segment
		end else if (sel < 70) begin
			nx = 0; ny = 0;
		end else if (sel < 75) begin
			nx = px; ny = py;
		end else if (sel < 80) begin
			if ($urandom_range(1)) begin
				px = cfg_ax; py = cfg_ay;
			end else begin
				nx = cfg_ex; ny = cfg_ey;
			end
		end else if (sel < 88) begin
			// both points on the line through A and B
			k = $urandom_range(0, 3); m = $urandom_range(0, 3);
			px = clip(cfg_ax - k * bx); py = clip(cfg_ay - k * by);
			nx = clip(cfg_ex + m * bx); ny = clip(cfg_ey + m * by);
		end else begin
			px = int'($urandom); py = int'($urandom);
		end
		send(px, py, nx, ny);
	endtask

	task automatic set_pressure(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
			default: begin send_idle_pct = 14; recv_stall_pct = 14; end
		endcase
	endtask

	initial begin
		int span;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.prev_x = '0; in_ch.prev_y = '0; in_ch.next_x = '0; in_ch.next_y = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0; recv_stall_pct = 0;
		idle_cycles = 0;
		cfg_ax = 0; cfg_ay = 0; cfg_ex = 0; cfg_ey = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// segment is a single point after reset: held point comes back
		send(5, 7, -3, 9);
		send(0, 0, 0, 0);

		set_segment(-1000, 0, 1000, 0);
		send(5, 5, 5, 5);                    // prev equals next
		send(-1000, 0, 40, 70);              // prev at A
		send(40, 70, 1000, 0);               // next at B
		send(-2000, 7, 0, 0);                // goal before A
		send(3000, 1, 0, 0);                 // goal past B
		send(10, 30, 0, 0);                  // goal inside
		send(0, 100, 500, 100);              // same side, mirrored
		send(0, 100, 500, -300);             // opposite sides
		send(-3000, 10, -2500, -10);         // crossing before A
		send(3000, 10, 2500, -10);           // crossing past B
		send(-5000, 0, 5000, 0);             // both on the line
		send(-1000, 10, -1000, -10);         // crossing exactly at A
		send(1000, -10, 1000, 10);           // crossing exactly at B
		send(CMAX, CMIN, CMIN, CMAX);
		send(CMIN, CMIN, CMAX, CMAX);
		send(CMIN, CMAX, 0, 0);

		// segment spanning the whole coordinate range
		set_segment(CMIN, CMIN, CMAX, CMAX);
		send(CMAX, CMIN, CMIN, CMAX);
		send(CMIN, CMAX, CMAX, CMIN);
		send(CMAX, 0, 0, 0);
		send(1, -1, -1, 1);
		send(CMAX, CMAX - 1, CMAX - 1, CMAX);

		for (int phase = 0; phase < 7; phase++) begin
			set_pressure(phase);
			case (phase)
				0: set_segment(int'($urandom), int'($urandom), int'($urandom),
					int'($urandom));
				1: set_segment($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
					$urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
				2: set_segment(CMAX, CMIN, CMIN, CMAX);
				3: set_segment(1234, -567, 1234, -567);
				4: set_segment(CMAX, CMAX, CMIN, CMIN);
				default: begin
					span = $urandom_range(3, 100000);
					set_segment($urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span);
				end
			endcase
			for (int i = 0; i < PHASE_LEN; i++)
				send_random();
		end

		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
